>>> src/lprw_pkg.sv
package lprw_pkg;

  // field widths of the request and result channels
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 16;
  localparam int SIZE_W = 21;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register reset values
  localparam logic [ADDR_W-1:0] REGION_START_RST = '0;
  localparam logic [SIZE_W-1:0] REGION_SIZE_RST  = SIZE_W'(4096);
  localparam logic [LEN_W-1:0]  MAX_LEN_RST      = LEN_W'(256);

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_REGION_START = 2'd0;
  localparam logic [CFG_W-1:0] CFG_REGION_SIZE  = 2'd1;
  localparam logic [CFG_W-1:0] CFG_MAX_LEN      = 2'd2;

  // request operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REGION = 2'd1,
    ST_MAXLEN = 2'd2,
    ST_ROOM   = 2'd3
  } status_t;

  typedef struct packed {
    logic              operation;
    logic [LEN_W-1:0]  message_length;
    logic [ADDR_W-1:0] reader_address;
    logic [DATA_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    status_t           status;
    logic [ADDR_W-1:0] pub;
    logic [CNT_W-1:0]  ovf;
    logic [CNT_W-1:0]  szerr;
    logic              last;
  } res_t;

endpackage

>>> src/lprw_in_reg.sv
module lprw_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lprw_pkg::item_t in_item,
  input  logic          take,
  output logic          full,
  output lprw_pkg::item_t item
);
  import lprw_pkg::*;

  // a request is held until the core takes it; a new one may enter the same cycle
  assign in_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> src/lprw_out_reg.sv
module lprw_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  input  lprw_pkg::res_t res,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output lprw_pkg::res_t out_res
);
  import lprw_pkg::*;

  // the slot takes a new result when empty or when the held one leaves
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_res <= res;
    end
  end

endmodule

>>> src/lprw_core.sv
module lprw_core #(
  parameter int HEADER_BYTES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lprw_pkg::CFG_W-1:0]  cfg_index,
  input  logic [lprw_pkg::ADDR_W-1:0] cfg_data,
  input  logic                        in_full,
  input  lprw_pkg::item_t             item,
  output logic                        take,
  input  logic                        slot_free,
  output logic                        res_valid,
  output lprw_pkg::res_t              res
);
  import lprw_pkg::*;

  localparam int NEED_W = $clog2(2**LEN_W + HEADER_BYTES);
  localparam int HL_W   = $clog2(HEADER_BYTES + 1);

  // configuration
  logic [ADDR_W-1:0] region_start;
  logic [SIZE_W-1:0] region_size;
  logic [LEN_W-1:0]  max_len;
  logic [ADDR_W:0]   region_end;

  // ring state
  logic [ADDR_W-1:0] write_pointer, write_pointer_next;
  logic [ADDR_W-1:0] working_pointer, working_pointer_next;
  logic [LEN_W-1:0]  bytes_remaining, bytes_remaining_next;
  logic              message_open, message_open_next;
  logic [CNT_W-1:0]  overflow_count, overflow_count_next;
  logic [CNT_W-1:0]  size_error_count, size_error_count_next;

  // header sequencer
  logic              status_pend, status_pend_next;
  logic [HL_W-1:0]   hdr_left, hdr_left_next;
  logic [LEN_W-1:0]  len_sh, len_sh_next;

  logic [NEED_W-1:0] need;
  logic [ADDR_W-1:0] size_ext;
  logic [ADDR_W-1:0] diff;
  logic [ADDR_W-1:0] free_cnt;
  logic [ADDR_W-1:0] wp_adv;
  logic [LEN_W-1:0]  br_dec;
  status_t           chk;

  // next address with wrap at the region end
  always_comb begin
    if ({1'b0, working_pointer} + {{ADDR_W{1'b0}}, 1'b1} >= region_end) begin
      wp_adv = region_start;
    end else begin
      wp_adv = working_pointer + 1'b1;
    end
  end

  // size and room checks of a start request
  always_comb begin
    need     = NEED_W'(HEADER_BYTES) + NEED_W'(item.message_length);
    size_ext = ADDR_W'(region_size);
    diff     = write_pointer - item.reader_address;
    if (item.reader_address > write_pointer) begin
      free_cnt = item.reader_address - write_pointer;
    end else if (diff > size_ext) begin
      free_cnt = '0;
    end else begin
      free_cnt = size_ext - diff;
    end
    if (SIZE_W'(need) >= region_size) begin
      chk = ST_REGION;
    end else if (need > NEED_W'(max_len)) begin
      chk = ST_MAXLEN;
    end else if (free_cnt <= ADDR_W'(need)) begin
      chk = ST_ROOM;
    end else begin
      chk = ST_OK;
    end
  end

  assign br_dec = bytes_remaining - 1'b1;

  // request handling and result generation
  always_comb begin
    write_pointer_next    = write_pointer;
    working_pointer_next  = working_pointer;
    bytes_remaining_next  = bytes_remaining;
    message_open_next     = message_open;
    overflow_count_next   = overflow_count;
    size_error_count_next = size_error_count;
    status_pend_next      = status_pend;
    hdr_left_next         = hdr_left;
    len_sh_next           = len_sh;
    take                  = 1'b0;
    res_valid             = 1'b0;
    res.kind              = KIND_BYTE;
    res.addr              = '0;
    res.data              = '0;
    res.status            = ST_OK;
    res.pub               = write_pointer;
    res.ovf               = overflow_count;
    res.szerr             = size_error_count;
    res.last              = 1'b0;

    if (status_pend) begin
      if (slot_free) begin
        res_valid = 1'b1;
        if (hdr_left != '0) begin
          // header byte, length least significant byte first
          res.addr             = working_pointer;
          res.data             = len_sh[DATA_W-1:0];
          working_pointer_next = wp_adv;
          len_sh_next          = len_sh >> DATA_W;
          hdr_left_next        = hdr_left - 1'b1;
        end else begin
          // closing status; an empty message commits here
          res.kind         = KIND_STATUS;
          res.last         = 1'b1;
          status_pend_next = 1'b0;
          if (!message_open) begin
            write_pointer_next = working_pointer;
            res.pub            = working_pointer;
          end
        end
      end
    end else if (in_full) begin
      if (item.operation == OP_START) begin
        if (chk == ST_OK) begin
          take                 = 1'b1;
          working_pointer_next = write_pointer;
          hdr_left_next        = HL_W'(HEADER_BYTES);
          len_sh_next          = item.message_length;
          status_pend_next     = 1'b1;
          message_open_next    = item.message_length != '0;
          bytes_remaining_next = item.message_length;
        end else if (slot_free) begin
          take                 = 1'b1;
          res_valid            = 1'b1;
          message_open_next    = 1'b0;
          bytes_remaining_next = '0;
          if (chk == ST_ROOM) begin
            if (overflow_count != CNT_MAX) begin
              overflow_count_next = overflow_count + 1'b1;
            end
          end else if (size_error_count != CNT_MAX) begin
            size_error_count_next = size_error_count + 1'b1;
          end
          res.kind   = KIND_STATUS;
          res.status = chk;
          res.ovf    = overflow_count_next;
          res.szerr  = size_error_count_next;
          res.last   = 1'b1;
        end
      end else if (!message_open) begin
        // payload with no open message is dropped
        take = 1'b1;
      end else if (slot_free) begin
        take                 = 1'b1;
        res_valid            = 1'b1;
        res.addr             = working_pointer;
        res.data             = item.data_byte;
        res.last             = 1'b1;
        working_pointer_next = wp_adv;
        bytes_remaining_next = br_dec;
        if (br_dec == '0) begin
          message_open_next  = 1'b0;
          write_pointer_next = wp_adv;
          res.pub            = wp_adv;
        end
      end
    end
  end

  // state registers; a region start write reloads the pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start     <= REGION_START_RST;
      region_size      <= REGION_SIZE_RST;
      max_len          <= MAX_LEN_RST;
      region_end       <= {1'b0, REGION_START_RST} + (ADDR_W+1)'(REGION_SIZE_RST);
      write_pointer    <= REGION_START_RST;
      working_pointer  <= REGION_START_RST;
      bytes_remaining  <= '0;
      message_open     <= 1'b0;
      overflow_count   <= '0;
      size_error_count <= '0;
      status_pend      <= 1'b0;
      hdr_left         <= '0;
    end else begin
      overflow_count   <= overflow_count_next;
      size_error_count <= size_error_count_next;
      status_pend      <= status_pend_next;
      hdr_left         <= hdr_left_next;
      if (cfg_write && cfg_index == CFG_REGION_START) begin
        region_start    <= cfg_data;
        region_end      <= {1'b0, cfg_data} + (ADDR_W+1)'(region_size);
        write_pointer   <= cfg_data;
        working_pointer <= cfg_data;
        bytes_remaining <= '0;
        message_open    <= 1'b0;
      end else begin
        write_pointer   <= write_pointer_next;
        working_pointer <= working_pointer_next;
        bytes_remaining <= bytes_remaining_next;
        message_open    <= message_open_next;
        if (cfg_write && cfg_index == CFG_REGION_SIZE) begin
          region_size <= cfg_data[SIZE_W-1:0];
          region_end  <= {1'b0, region_start} + (ADDR_W+1)'(cfg_data[SIZE_W-1:0]);
        end else if (cfg_write && cfg_index == CFG_MAX_LEN) begin
          max_len <= cfg_data[LEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    len_sh <= len_sh_next;
  end

endmodule

>>> src/length_prefixed_ring_writer_top.sv
// channel   direction  handshake            payload
// in        request    in_valid/in_ready    operation, message_length, reader_address, data_byte
// out       result     out_valid/out_ready  result_kind .. last_result
// cfg       write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a payload byte of an open message or a refused start gives one result; an accepted start gives
// HEADER_BYTES header bytes and a closing status, one result per cycle while out_ready is high
// a request is held in the input register while the header sequencer runs
// out_ready low stalls the output register and, through it, the core
// reset is synchronous; no clearing pass, the block is ready right after reset
module length_prefixed_ring_writer_top #(
  parameter int HEADER_BYTES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [lprw_pkg::LEN_W-1:0]  message_length,
  input  logic [lprw_pkg::ADDR_W-1:0] reader_address,
  input  logic [lprw_pkg::DATA_W-1:0] data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        result_kind,
  output logic [lprw_pkg::ADDR_W-1:0] mem_address,
  output logic [lprw_pkg::DATA_W-1:0] mem_byte,
  output logic [1:0]                  start_status,
  output logic [lprw_pkg::ADDR_W-1:0] published_pointer,
  output logic [lprw_pkg::CNT_W-1:0]  overflow_errors,
  output logic [lprw_pkg::CNT_W-1:0]  size_errors,
  output logic                        last_result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lprw_pkg::CFG_W-1:0]  cfg_index,
  input  logic [lprw_pkg::ADDR_W-1:0] cfg_data
);
  import lprw_pkg::*;

  item_t in_item;
  item_t item;
  res_t  res;
  res_t  out_res;
  logic  full;
  logic  take;
  logic  slot_free;
  logic  res_valid;

  assign cfg_ready = 1'b1;

  assign in_item.operation      = operation;
  assign in_item.message_length = message_length;
  assign in_item.reader_address = reader_address;
  assign in_item.data_byte      = data_byte;

  lprw_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .full     (full),
    .item     (item)
  );

  lprw_core #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_full   (full),
    .item      (item),
    .take      (take),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  lprw_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // result fields
  assign result_kind       = out_res.kind;
  assign mem_address       = out_res.addr;
  assign mem_byte          = out_res.data;
  assign start_status      = out_res.status;
  assign published_pointer = out_res.pub;
  assign overflow_errors   = out_res.ovf;
  assign size_errors       = out_res.szerr;
  assign last_result       = out_res.last;

endmodule
